FILE: design/nsa_pkg.sv
// ----------------------------------------------------------------------------
// nsa_pkg
// shared constants and types for the nearest subcentroid assignment block
// ----------------------------------------------------------------------------
package nsa_pkg;

  // default sizes of the subcentroid table
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_MAX_DIMS    = 128;

  // field and register widths
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 39;
  localparam int SQ_W     = 2 * VAL_W;
  localparam int ENTRY_W  = 4;
  localparam int ELEM_W   = 7;
  localparam int ACTIVE_W = 5;
  localparam int DIMS_W   = 8;
  localparam int REG_IDX_W = 1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_ENTRIES = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DIMS_IN_USE    = 1'b1;

  // register reset values
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [DIMS_W-1:0]   DIMS_RESET   = 8'd128;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_t;

endpackage

FILE: design/nsa_ram.sv
// ----------------------------------------------------------------------------
// nsa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/nearest_subcentroid_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_subcentroid_assign_top
// squared l2 nearest subcentroid search over a table held in ram
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | func, entry, element, value,
//           |                        | final_point
//  output   | out_valid / out_ready  | nearest_entry, nearest_distance,
//           |                        | group_done
//  config   | wr_en                  | wr_index, wr_data
//
//  a load word or an ignored point word is taken without an entry sweep
//  a point word in range starts a sweep over the n active entries: the
//  subcentroid ram read port visits one entry per cycle, then three stages
//  of difference, square and accumulate drain
//  reset clears control state and the sum valid bits, no clearing pass
//  a waiting result does not stop the next word; a second finished result
//  is parked and input stalls until the output side takes the first
// ----------------------------------------------------------------------------
module nearest_subcentroid_assign_top #(
  parameter int MAX_ENTRIES = nsa_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_DIMS    = nsa_pkg::DEF_MAX_DIMS
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           wr_en,
  input  logic [nsa_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [nsa_pkg::DIMS_W-1:0]     wr_data,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [nsa_pkg::ENTRY_W-1:0]    entry,
  input  logic [nsa_pkg::ELEM_W-1:0]     element,
  input  logic signed [nsa_pkg::VAL_W-1:0] value,
  input  logic                           final_point,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nsa_pkg::ENTRY_W-1:0]    nearest_entry,
  output logic [nsa_pkg::SUM_W-1:0]      nearest_distance,
  output logic                           group_done
);

  import nsa_pkg::*;

  localparam int ENT_W   = $clog2(MAX_ENTRIES);
  localparam int ST_DEPTH = MAX_ENTRIES * MAX_DIMS;
  localparam int ST_AW   = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

  // configuration registers
  logic [ACTIVE_W-1:0] active_entries;
  logic [DIMS_W-1:0]   dims_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
      dims_in_use    <= DIMS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ACTIVE_ENTRIES: active_entries <= wr_data[ACTIVE_W-1:0];
        REG_DIMS_IN_USE:    dims_in_use    <= wr_data;
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [ACTIVE_W-1:0] eff_n;
  logic [DIMS_W-1:0]   eff_dims;
  logic [ENT_W-1:0]    n_last;

  always_comb begin
    if (active_entries == '0) begin
      eff_n = ACTIVE_W'(1);
    end else if (int'(active_entries) > MAX_ENTRIES) begin
      eff_n = ACTIVE_W'(MAX_ENTRIES);
    end else begin
      eff_n = active_entries;
    end
    if (dims_in_use == '0) begin
      eff_dims = DIMS_W'(1);
    end else if (int'(dims_in_use) > MAX_DIMS) begin
      eff_dims = DIMS_W'(MAX_DIMS);
    end else begin
      eff_dims = dims_in_use;
    end
    n_last = ENT_W'(eff_n - ACTIVE_W'(1));
  end

  // input word decode
  seq_state_t state, state_next;
  logic       pend_v;
  logic       in_fire;
  logic       load_ok;
  logic       point_ok;
  logic       start;

  assign in_ready = (state == ST_IDLE) && !pend_v;
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = (int'(entry) < MAX_ENTRIES) && (int'(element) < MAX_DIMS);
  assign point_ok = {1'b0, element} < eff_dims;
  assign start    = in_fire && (func == FUNC_POINT) && point_ok;

  // item held for the entry sweep
  logic signed [VAL_W-1:0] item_value;
  logic [ELEM_W-1:0]       item_element;
  logic                    item_final;
  logic                    item_emit;

  always_ff @(posedge clk) begin
    if (start) begin
      item_value   <= value;
      item_element <= element;
      item_final   <= final_point;
      item_emit    <= ({1'b0, element} == (eff_dims - DIMS_W'(1)));
    end
  end

  // sequencer state register
  logic [ENT_W-1:0] e_cnt;
  logic             issue;
  logic             s3_v;
  logic             s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (e_cnt == n_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s3_v && s3_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      e_cnt <= '0;
    end else if (start) begin
      e_cnt <= '0;
    end else if (issue) begin
      e_cnt <= e_cnt + ENT_W'(1);
    end
  end

  // subcentroid memory
  logic             st_we;
  logic [ST_AW-1:0] st_waddr;
  logic [ST_AW-1:0] st_raddr;
  logic [VAL_W-1:0] st_rdata;

  assign st_we    = in_fire && (func == FUNC_LOAD) && load_ok;
  assign st_waddr = ST_AW'(int'(entry) * MAX_DIMS + int'(element));
  assign st_raddr = ST_AW'(int'(e_cnt) * MAX_DIMS + int'(item_element));

  nsa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // distance sum memory, entries without a valid bit read as zero
  logic [SUM_W-1:0]       sum_rdata;
  logic [SUM_W-1:0]       sum_new;
  logic [ENT_W-1:0]       s3_e;
  logic [MAX_ENTRIES-1:0] sum_vld;

  nsa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_sums (
    .clk   (clk),
    .we    (s3_v),
    .waddr (s3_e),
    .wdata (sum_new),
    .raddr (e_cnt),
    .rdata (sum_rdata)
  );

  // sum valid bits, element zero restarts every sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= '0;
    end else if (start && (element == '0)) begin
      sum_vld <= '0;
    end else if (s3_v) begin
      sum_vld[s3_e] <= 1'b1;
    end
  end

  // pipeline control
  logic             s1_v, s2_v;
  logic             s1_last, s2_last;
  logic [ENT_W-1:0] s1_e, s2_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // stage 1: magnitude of the difference
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        diff_abs;
  logic [VAL_W-1:0]      s2_mag;
  logic [SUM_W-1:0]      s2_old;

  assign diff     = {item_value[VAL_W-1], item_value} - {st_rdata[VAL_W-1], st_rdata};
  assign diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    s1_e    <= e_cnt;
    s1_last <= (e_cnt == n_last);
    s2_e    <= s1_e;
    s2_last <= s1_last;
    s2_mag  <= diff_abs[VAL_W-1:0];
    s2_old  <= sum_vld[s1_e] ? sum_rdata : '0;
  end

  // stage 2: square
  logic [SQ_W-1:0]  s3_sq;
  logic [SUM_W-1:0] s3_old;

  always_ff @(posedge clk) begin
    s3_e    <= s2_e;
    s3_last <= s2_last;
    s3_old  <= s2_old;
    s3_sq   <= s2_mag * s2_mag;
  end

  // stage 3: saturating accumulate and running minimum
  logic [SUM_W:0]   sum_ext;
  logic [ENT_W-1:0] best_e, cur_e;
  logic [SUM_W-1:0] best_sum, cur_sum;
  logic             take;
  logic             emit;

  assign sum_ext = {1'b0, s3_old} + (SUM_W+1)'(s3_sq);
  assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign take    = (s3_e == '0) || (sum_new < best_sum);
  assign cur_e   = take ? s3_e : best_e;
  assign cur_sum = take ? sum_new : best_sum;
  assign emit    = s3_v && s3_last && item_emit;

  always_ff @(posedge clk) begin
    if (s3_v) begin
      best_e   <= cur_e;
      best_sum <= cur_sum;
    end
  end

  // output register with one parked result behind it
  logic [ENTRY_W-1:0] pend_entry;
  logic [SUM_W-1:0]   pend_dist;
  logic               pend_group;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else if (emit && out_valid && !out_ready) begin
      // output register still held, park the new result
      pend_entry <= ENTRY_W'(cur_e);
      pend_dist  <= cur_sum;
      pend_group <= item_final;
      pend_v     <= 1'b1;
    end else if (emit) begin
      nearest_entry    <= ENTRY_W'(cur_e);
      nearest_distance <= cur_sum;
      group_done       <= item_final;
      out_valid        <= 1'b1;
    end else if (out_valid && out_ready) begin
      if (pend_v) begin
        nearest_entry    <= pend_entry;
        nearest_distance <= pend_dist;
        group_done       <= pend_group;
        pend_v           <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks on the sequencer and the result queue
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> out_valid)
    else $error("parked result without a result in the output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input accepted during an entry sweep");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (state != ST_IDLE))
    else $error("accumulate stage active with the sequencer idle");

  a_pend_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(pend_v) |-> $past(s3_v && s3_last))
    else $error("result parked without a finished sweep");

endmodule

FILE: sim/nearest_subcentroid_assign_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_subcentroid_assign_top_tb
// self-checking bench for the nearest subcentroid assignment block
//
// loads subcentroid tables, streams query points and checks every nearest
// entry and squared distance against a predictor kept in a scoreboard class.
// a short directed part covers value extremes, ties, ignored elements and
// clamped registers; random phases then vary both registers, mix whole
// points with broken, out-of-order and ignored words, and idle both sides.
// ----------------------------------------------------------------------------
module nearest_subcentroid_assign_top_tb;
  import nsa_pkg::*;

  localparam int N_ENTRIES   = DEF_MAX_ENTRIES;
  localparam int N_DIMS      = DEF_MAX_DIMS;
  localparam int WORD_TARGET = 1600;
  localparam int SETTLE      = DEF_MAX_ENTRIES + 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ENTRY_W-1:0] nearest;
    logic [SUM_W-1:0]   distance;
    logic               done;
  } assignment_t;

  // predictor of the block plus the queue of assignments still to arrive
  class assign_tracker;
    logic signed [VAL_W-1:0] codebook [N_ENTRIES][N_DIMS];
    logic [SUM_W-1:0]        run_sum [N_ENTRIES];
    logic [ACTIVE_W-1:0]     active_reg;
    logic [DIMS_W-1:0]       dims_reg;
    assignment_t             pending_assignments [$];
    int                      errors;
    int                      results_seen;

    function new();
      active_reg   = ACTIVE_RESET;
      dims_reg     = DIMS_RESET;
      errors       = 0;
      results_seen = 0;
      foreach (run_sum[i]) run_sum[i] = '0;
      foreach (codebook[i, j]) codebook[i][j] = '0;
    endfunction

    static function int unsigned eff_entries(logic [ACTIVE_W-1:0] r);
      if (r < 1) return 1;
      if (r > N_ENTRIES) return N_ENTRIES;
      return r;
    endfunction

    static function int unsigned eff_dims(logic [DIMS_W-1:0] r);
      if (r < 1) return 1;
      if (r > N_DIMS) return N_DIMS;
      return r;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DIMS_W-1:0] data);
      if (idx == REG_ACTIVE_ENTRIES) active_reg = data[ACTIVE_W-1:0];
      else dims_reg = data;
    endfunction

    function int pending();
      return pending_assignments.size();
    endfunction

    // update the table or the running sums for one accepted word
    function void note_word(logic f, logic [ENTRY_W-1:0] ent, logic [ELEM_W-1:0] el,
                            logic signed [VAL_W-1:0] v, logic fp);
      int unsigned n;
      int unsigned dims;
      longint      diff;
      logic [SUM_W:0] acc;
      assignment_t res;
      if (f == FUNC_LOAD) begin
        codebook[ent][el] = v;
        return;
      end
      dims = eff_dims(dims_reg);
      if (el >= dims) return;
      if (el == 0) foreach (run_sum[i]) run_sum[i] = '0;
      n = eff_entries(active_reg);
      for (int e = 0; e < n; e++) begin
        diff = longint'(v) - longint'(codebook[e][el]);
        acc  = {1'b0, run_sum[e]} + (SUM_W+1)'(diff * diff);
        run_sum[e] = (acc > {1'b0, SUM_CEIL}) ? SUM_CEIL : acc[SUM_W-1:0];
      end
      if (el != dims - 1) return;
      // strict compare keeps the lowest index on ties
      res.nearest  = '0;
      res.distance = run_sum[0];
      res.done     = fp;
      for (int e = 1; e < n; e++) begin
        if (run_sum[e] < res.distance) begin
          res.distance = run_sum[e];
          res.nearest  = ENTRY_W'(e);
        end
      end
      pending_assignments.insert(pending_assignments.size(), res);
    endfunction

    function void check_result(logic [ENTRY_W-1:0] ne, logic [SUM_W-1:0] nd, logic gd);
      assignment_t exp_res;
      results_seen++;
      if (pending_assignments.size() == 0) begin
        $error("unexpected result word: nearest_entry %0d, nearest_distance %0d", ne, nd);
        errors++;
        return;
      end
      exp_res = pending_assignments.pop_front();
      if (ne !== exp_res.nearest) begin
        $error("nearest_entry mismatch: expected %0d, actual %0d", exp_res.nearest, ne);
        errors++;
      end
      if (nd !== exp_res.distance) begin
        $error("nearest_distance mismatch: expected %0d, actual %0d", exp_res.distance, nd);
        errors++;
      end
      if (gd !== exp_res.done) begin
        $error("group_done mismatch: expected %0d, actual %0d", exp_res.done, gd);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      wr_en;
  logic [REG_IDX_W-1:0]      wr_index;
  logic [DIMS_W-1:0]         wr_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      func;
  logic [ENTRY_W-1:0]        entry;
  logic [ELEM_W-1:0]         element;
  logic signed [VAL_W-1:0]   value;
  logic                      final_point;
  logic                      out_valid;
  logic                      out_ready;
  logic [ENTRY_W-1:0]        nearest_entry;
  logic [SUM_W-1:0]          nearest_distance;
  logic                      group_done;

  assign_tracker sb;
  bit            written [N_ENTRIES][N_DIMS];
  int            words_sent;
  int            cycles;
  int            phase;
  bit            src_steady;
  bit            sink_steady;

  nearest_subcentroid_assign_top dut (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .entry            (entry),
    .element          (element),
    .value            (value),
    .final_point      (final_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .nearest_entry    (nearest_entry),
    .nearest_distance (nearest_distance),
    .group_done       (group_done)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random hold-offs after each taken word
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(nearest_entry, nearest_distance, group_done);
        hold = sink_steady ? 0 : $urandom_range(0, 16);
        if (hold != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        hold = hold - 1;
        if (hold == 0) out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    v = VAL_W'($urandom);
    case ($urandom_range(0, 7))
      0: v = 16'sh8000;
      1: v = 16'sh7FFF;
      default: ;
    endcase
    return v;
  endfunction

  // one word on the input channel, after a random gap
  task automatic send_word(input logic f, input logic [ENTRY_W-1:0] ent,
                           input logic [ELEM_W-1:0] el, input logic signed [VAL_W-1:0] v,
                           input logic fp);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    entry       <= ent;
    element     <= el;
    value       <= v;
    final_point <= fp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(f, ent, el, v, fp);
    words_sent++;
    if (f == FUNC_LOAD) written[ent][el] = 1'b1;
  endtask

  task automatic load_word(input logic [ENTRY_W-1:0] ent, input logic [ELEM_W-1:0] el,
                           input logic signed [VAL_W-1:0] v);
    logic fp;
    fp = 1'($urandom);
    send_word(FUNC_LOAD, ent, el, v, fp);
  endtask

  task automatic point_word(input logic [ELEM_W-1:0] el, input logic signed [VAL_W-1:0] v,
                            input logic fp);
    logic [ENTRY_W-1:0] junk;
    junk = ENTRY_W'($urandom);
    send_word(FUNC_POINT, junk, el, v, fp);
  endtask

  // drop valid, wait for every result and for the pipeline to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [DIMS_W-1:0] act, input logic [DIMS_W-1:0] dims);
    wr_en    <= 1'b1;
    wr_index <= REG_ACTIVE_ENTRIES;
    wr_data  <= act;
    @(posedge clk);
    sb.write_reg(REG_ACTIVE_ENTRIES, act);
    wr_index <= REG_DIMS_IN_USE;
    wr_data  <= dims;
    @(posedge clk);
    sb.write_reg(REG_DIMS_IN_USE, dims);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one configuration followed by a group of points
  task automatic run_phase(input bit big, input bit extreme);
    logic [DIMS_W-1:0] a_wr;
    logic [DIMS_W-1:0] d_wr;
    int unsigned n;
    int unsigned dims;
    int unsigned npts;
    int unsigned style;
    int unsigned cnt;
    int unsigned r;
    logic        fp;

    // register values, out-of-range ones included
    if (big) begin
      a_wr = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd0;
      d_wr = ($urandom_range(0, 1) != 0) ? 8'd128 : 8'($urandom_range(129, 255));
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0) a_wr = 8'd0;
      else if (r == 1) a_wr = 8'($urandom_range(17, 255));
      else if (r == 2) a_wr = 8'd16;
      else if (r == 3) a_wr = 8'd1;
      else a_wr = 8'($urandom_range(1, 16));
      r = $urandom_range(0, 9);
      if (r == 0) d_wr = 8'd0;
      else if (r == 1) d_wr = 8'd1;
      else if (r == 2) d_wr = 8'($urandom_range(9, 32));
      else d_wr = 8'($urandom_range(1, 8));
    end
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    wait_idle();
    set_config(a_wr, d_wr);
    n    = assign_tracker::eff_entries(a_wr[ACTIVE_W-1:0]);
    dims = assign_tracker::eff_dims(d_wr);

    // fill every element that the points will read
    for (int e = 0; e < n; e++)
      for (int k = 0; k < dims; k++)
        if (extreme) load_word(ENTRY_W'(e), ELEM_W'(k), 16'sh8000);
        else if (!written[e][k]) load_word(ENTRY_W'(e), ELEM_W'(k), pick_value());

    npts = big ? 2 : $urandom_range(4, 20);
    for (int p = 0; p < npts; p++) begin
      fp    = (p == npts - 1);
      style = big ? 0 : $urandom_range(0, 9);
      if (style < 7) begin
        // whole point, with the odd stray word in between
        for (int k = 0; k < dims; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            if (dims < N_DIMS && $urandom_range(0, 1) != 0)
              point_word(ELEM_W'($urandom_range(dims, N_DIMS - 1)), pick_value(), fp);
            else
              load_word(ENTRY_W'($urandom), ELEM_W'($urandom), pick_value());
          end
          point_word(ELEM_W'(k), extreme ? 16'sh7FFF : pick_value(), fp);
        end
      end else if (style == 7) begin
        // broken point, restarted by the next element 0
        if (dims > 1) begin
          cnt = $urandom_range(1, dims - 1);
          for (int k = 0; k < cnt; k++) point_word(ELEM_W'(k), pick_value(), 1'($urandom));
        end
      end else if (style == 8) begin
        // elements in random order
        cnt = $urandom_range(1, 2 * dims);
        for (int k = 0; k < cnt; k++)
          point_word(ELEM_W'($urandom_range(0, dims - 1)), pick_value(), 1'($urandom));
      end else begin
        // ignored elements and stray loads
        cnt = $urandom_range(1, 8);
        for (int k = 0; k < cnt; k++) begin
          if (dims < N_DIMS && $urandom_range(0, 1) != 0)
            point_word(ELEM_W'($urandom_range(dims, N_DIMS - 1)), pick_value(),
                       1'($urandom));
          else
            load_word(ENTRY_W'($urandom), ELEM_W'($urandom), pick_value());
        end
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    rst         <= 1'b1;
    wr_en       <= 1'b0;
    wr_index    <= REG_ACTIVE_ENTRIES;
    wr_data     <= '0;
    in_valid    <= 1'b0;
    func        <= FUNC_LOAD;
    entry       <= '0;
    element     <= '0;
    value       <= '0;
    final_point <= 1'b0;
    sb          = new();
    words_sent  = 0;
    phase       = 0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    foreach (written[i, j]) written[i][j] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two entries, one dimension
    set_config(8'd2, 8'd1);
    load_word(4'd15, 7'd127, 16'sh5AA5);
    load_word(4'd0, 7'd0, 16'sh8000);
    load_word(4'd1, 7'd0, 16'sh7FFF);
    point_word(7'd0, 16'sh7FFF, 1'b0);
    point_word(7'd0, 16'sh8000, 1'b1);
    point_word(7'd0, 16'sh0000, 1'b0);
    // elements past the dimension are ignored
    point_word(7'd5, 16'sh0000, 1'b0);
    point_word(7'd127, -16'sd1, 1'b1);
    // equal distances go to the lower entry
    load_word(4'd1, 7'd0, 16'sh8000);
    point_word(7'd0, 16'sh0000, 1'b1);
    point_word(7'd0, 16'sh7FFF, 1'b0);
    // zero registers clamp to one entry and one dimension
    wait_idle();
    set_config(8'd0, 8'd0);
    point_word(7'd0, 16'sd100, 1'b1);
    point_word(7'd1, 16'sd100, 1'b0);

    // random phases, two of them at full dimension
    while (words_sent < WORD_TARGET) begin
      run_phase(phase == 1 || phase == 6, phase == 1);
      phase++;
    end

    wait_idle();
    $display("%0d input words accepted, %0d assignments checked", words_sent, sb.results_seen);
    $display("%0d random phases over 1 to 16 entries and 1 to 128 dimensions", phase);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
design/nsa_pkg.sv
design/nsa_ram.sv
design/nearest_subcentroid_assign_top.sv
sim/nearest_subcentroid_assign_top_tb.sv
